/* rtl/ifps_pkg.sv */
// ----------------------------------------------------------------------------
// ifps_pkg
// Types, constants and helper functions shared by the fill/pack sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ifps_pkg;

  // Action codes carried by a request.
  localparam logic [1:0] ActTick  = 2'd0;
  localparam logic [1:0] ActStart = 2'd1;
  localparam logic [1:0] ActReset = 2'd2;

  // Phase codes reported on the result channel.
  localparam logic [1:0] PhaseDone = 2'd0;
  localparam logic [1:0] PhaseFill = 2'd1;
  localparam logic [1:0] PhasePack = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegFillVolume     = 3'd0;
  localparam logic [2:0] RegPackVolume     = 3'd1;
  localparam logic [2:0] RegPackTimeMs     = 3'd2;
  localparam logic [2:0] RegTurnsPerVolume = 3'd3;
  localparam logic [2:0] RegPositionLimit  = 3'd4;
  localparam logic [2:0] RegCommandGapMs   = 3'd5;

  localparam int unsigned AddrW = 5;

  // Thresholds: 0.1 turn/s and one turn in Q16.16, times in ms.
  localparam logic signed [31:0] VelLowMax     = 32'sd6553;
  localparam logic signed [32:0] OneTurn       = 33'sd65536;
  localparam logic [31:0]        SettleMs      = 32'd500;
  localparam logic [31:0]        FillTimeoutMs = 32'd30000;

  // Sequencer state, one-hot.
  typedef enum logic [2:0] {
    StDone = 3'b001,
    StFill = 3'b010,
    StPack = 3'b100
  } seq_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [31:0] motor_position;
    logic [31:0] motor_velocity;
  } item_t;

  typedef struct packed {
    logic        set_position_mode;
    logic        send_position;
    logic [31:0] position_value;
    logic        send_stop;
    logic        finished;
    logic [1:0]  phase_now;
    logic        complete_ok;
    logic        error_flag;
  } result_t;

  typedef struct packed {
    seq_state_e  st;
    logic        entry_pending;
    logic [31:0] phase_start_ms;
    logic [31:0] last_command_ms;
    logic [31:0] fill_target;
    logic [31:0] pack_target;
    logic        complete;
    logic        error;
  } seq_t;

  // Configuration as seen by the step logic, volume offsets already scaled.
  typedef struct packed {
    logic [31:0] fill_offset;
    logic [31:0] pack_offset;
    logic [23:0] pack_time_ms;
    logic [31:0] position_limit;
    logic [15:0] command_gap_ms;
  } cfg_t;

  // Target = position + offset, clamped from above to the limit.
  function automatic logic [31:0] make_target(input logic [31:0] pos,
                                              input logic [31:0] offset,
                                              input logic [31:0] limit);
    logic signed [33:0] sum;
    logic signed [33:0] lim;
    sum = $signed({pos[31], pos[31], pos}) + $signed({2'b00, offset});
    lim = $signed({limit[31], limit[31], limit});
    if (sum > lim) begin
      return limit;
    end
    return sum[31:0];
  endfunction

  function automatic logic [1:0] phase_code(input seq_state_e st);
    case (st)
      StFill:  return PhaseFill;
      StPack:  return PhasePack;
      default: return PhaseDone;
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/ifps_if.sv */
// ----------------------------------------------------------------------------
// ifps_in_if / ifps_out_if
// Valid/ready channels for sequencer requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] now_ms;
  logic [31:0] motor_position;
  logic [31:0] motor_velocity;

  modport source (output valid, action, now_ms, motor_position, motor_velocity,
                  input ready);
  modport sink (input valid, action, now_ms, motor_position, motor_velocity,
                output ready);
endinterface

interface ifps_out_if;
  logic        valid;
  logic        ready;
  logic        set_position_mode;
  logic        send_position;
  logic [31:0] position_value;
  logic        send_stop;
  logic        finished;
  logic [1:0]  phase_now;
  logic        complete_ok;
  logic        error_flag;

  modport source (output valid, set_position_mode, send_position, position_value,
                  send_stop, finished, phase_now, complete_ok, error_flag,
                  input ready);
  modport sink (input valid, set_position_mode, send_position, position_value,
                send_stop, finished, phase_now, complete_ok, error_flag,
                output ready);
endinterface

`default_nettype wire

/* rtl/injection_fill_pack_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// injection_fill_pack_sequencer_unit
// Fill/pack plunger sequencer. Requests enter on in_i (valid/ready) and carry
// an action (tick, start, reset), a millisecond timestamp and the measured
// motor position and velocity. Each tick request yields one result on out_o:
// mode and position commands, stop, finished flag, phase and status. Start
// and reset requests update the sequencer and yield no result.
// Registers are to be written over the APB-style port only while no request is
// in flight; the block itself does not enforce it. A result passes the input
// register, then the result register. Throughput: one request per cycle while the
// receiver does not stall; the sequencer state is updated in the same cycle the
// result is registered, so back-to-back requests see each other's state.
// After reset the sequencer sits in the done phase with all registers at
// their reset values and no pending entry.
// When the receiver stalls, the result register holds its value, the next tick
// request waits in the input register, and then in_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module injection_fill_pack_sequencer_unit import ifps_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ifps_in_if.sink               in_i,
  ifps_out_if.source            out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  seq_t    seq_q, seq_d;
  result_t res_d, res_q;
  logic    res_valid_q;
  logic    has_result;
  logic    in_acc;
  logic    item_adv;

  ifps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ifps_step u_step (
    .cfg_i        (cfg),
    .item_i       (item_q),
    .seq_i        (seq_q),
    .seq_o        (seq_d),
    .res_o        (res_d),
    .has_result_o (has_result)
  );

  // The held request moves on when it makes no result or the result slot frees.
  assign item_adv   = item_valid_q && (!has_result || !res_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || item_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_acc) begin
      item_valid_q <= 1'b1;
    end else if (item_adv) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.action         <= in_i.action;
      item_q.now_ms         <= in_i.now_ms;
      item_q.motor_position <= in_i.motor_position;
      item_q.motor_velocity <= in_i.motor_velocity;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q.st              <= StDone;
      seq_q.entry_pending   <= 1'b0;
      seq_q.phase_start_ms  <= 32'd0;
      seq_q.last_command_ms <= 32'd0;
      seq_q.fill_target     <= 32'd0;
      seq_q.pack_target     <= 32'd0;
      seq_q.complete        <= 1'b0;
      seq_q.error           <= 1'b0;
    end else if (item_adv) begin
      seq_q <= seq_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (item_adv && has_result) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_adv && has_result) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid             = res_valid_q;
  assign out_o.set_position_mode = res_q.set_position_mode;
  assign out_o.send_position     = res_q.send_position;
  assign out_o.position_value    = res_q.position_value;
  assign out_o.send_stop         = res_q.send_stop;
  assign out_o.finished          = res_q.finished;
  assign out_o.phase_now         = res_q.phase_now;
  assign out_o.complete_ok       = res_q.complete_ok;
  assign out_o.error_flag        = res_q.error_flag;

endmodule

`default_nettype wire

/* rtl/ifps_cfg.sv */
// ----------------------------------------------------------------------------
// ifps_cfg
// Configuration registers behind an APB-style port, plus the registered
// volume-to-turns offsets derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

module ifps_cfg import ifps_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [23:0] fill_volume_q, pack_volume_q, pack_time_q, turns_q;
  logic [31:0] limit_q;
  logic [15:0] gap_q;
  logic [31:0] fill_offset_q, pack_offset_q;
  logic [47:0] fill_prod, pack_prod;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_volume_q <= 24'd0;
      pack_volume_q <= 24'd0;
      pack_time_q   <= 24'd0;
      turns_q       <= 24'd65536;
      limit_q       <= 32'h7FFF_FFFF;
      gap_q         <= 16'd10;
    end else if (wr_en) begin
      case (reg_idx)
        RegFillVolume:     fill_volume_q <= pwdata[23:0];
        RegPackVolume:     pack_volume_q <= pwdata[23:0];
        RegPackTimeMs:     pack_time_q   <= pwdata[23:0];
        RegTurnsPerVolume: turns_q       <= pwdata[23:0];
        RegPositionLimit:  limit_q       <= pwdata;
        RegCommandGapMs:   gap_q         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      RegFillVolume:     prdata = {8'd0, fill_volume_q};
      RegPackVolume:     prdata = {8'd0, pack_volume_q};
      RegPackTimeMs:     prdata = {8'd0, pack_time_q};
      RegTurnsPerVolume: prdata = {8'd0, turns_q};
      RegPositionLimit:  prdata = limit_q;
      RegCommandGapMs:   prdata = {16'd0, gap_q};
      default:           prdata = 32'd0;
    endcase
  end

  // Volume times turns per volume, Q8.16 by Q8.16, truncated back to Q16.16.
  // The offsets only change with the registers, so they are registered once
  // here and the per-request path sees no multiplier.
  assign fill_prod = 48'(fill_volume_q) * 48'(turns_q);
  assign pack_prod = 48'(pack_volume_q) * 48'(turns_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_offset_q <= 32'd0;
      pack_offset_q <= 32'd0;
    end else begin
      fill_offset_q <= fill_prod[47:16];
      pack_offset_q <= pack_prod[47:16];
    end
  end

  assign cfg_o.fill_offset    = fill_offset_q;
  assign cfg_o.pack_offset    = pack_offset_q;
  assign cfg_o.pack_time_ms   = pack_time_q;
  assign cfg_o.position_limit = limit_q;
  assign cfg_o.command_gap_ms = gap_q;

endmodule

`default_nettype wire

/* rtl/ifps_step.sv */
// ----------------------------------------------------------------------------
// ifps_step
// Next-state and result logic for one request of the fill/pack sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ifps_step import ifps_pkg::*; (
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  seq_t    seq_i,
  output seq_t    seq_o,
  output result_t res_o,
  output logic    has_result_o
);

  logic [31:0]        now;
  logic [31:0]        pos;
  logic signed [31:0] vel;
  logic [31:0]        elapsed;
  logic [31:0]        last_cmd;
  logic [31:0]        ft;
  logic [31:0]        pt_new;
  logic [16:0]        gap2;
  logic               resend;
  logic               vel_low;
  logic               close;
  logic signed [32:0] diff;

  assign now  = item_i.now_ms;
  assign pos  = item_i.motor_position;
  assign vel  = $signed(item_i.motor_velocity);
  assign gap2 = {cfg_i.command_gap_ms, 1'b0};

  assign elapsed = now - seq_i.phase_start_ms;

  // Fill target: freshly computed on the entry tick, held otherwise.
  assign ft       = seq_i.entry_pending ?
                    make_target(pos, cfg_i.fill_offset, cfg_i.position_limit) :
                    seq_i.fill_target;
  assign last_cmd = seq_i.entry_pending ? now : seq_i.last_command_ms;
  assign resend   = (now - last_cmd) >= {15'd0, gap2};
  assign pt_new   = make_target(pos, cfg_i.pack_offset, cfg_i.position_limit);

  // Settle checks for the move from fill to pack.
  assign vel_low = (vel <= VelLowMax) && (vel >= -VelLowMax);
  assign diff    = $signed({pos[31], pos}) - $signed({ft[31], ft});
  assign close   = (diff < OneTurn) && (diff > -OneTurn);

  always_comb begin
    seq_o        = seq_i;
    res_o        = '0;
    has_result_o = 1'b0;

    case (item_i.action)
      ActStart: begin
        seq_o.st              = StFill;
        seq_o.entry_pending   = 1'b1;
        seq_o.phase_start_ms  = now;
        seq_o.last_command_ms = now;
        seq_o.complete        = 1'b0;
        seq_o.error           = 1'b0;
      end

      ActReset: begin
        seq_o.st            = StDone;
        seq_o.entry_pending = 1'b1;
        seq_o.complete      = 1'b0;
        seq_o.error         = 1'b0;
      end

      ActTick: begin
        has_result_o = 1'b1;

        // Entry tick: mode command and the fill target.
        if (seq_i.entry_pending) begin
          seq_o.fill_target       = ft;
          seq_o.last_command_ms   = now;
          seq_o.entry_pending     = 1'b0;
          res_o.set_position_mode = 1'b1;
          res_o.send_position     = 1'b1;
          res_o.position_value    = ft;
        end

        case (seq_i.st)
          StFill: begin
            if (resend) begin
              res_o.send_position   = 1'b1;
              res_o.position_value  = ft;
              seq_o.last_command_ms = now;
            end
            if (vel_low && (elapsed > SettleMs) && close) begin
              seq_o.st              = StPack;
              seq_o.phase_start_ms  = now;
              seq_o.pack_target     = pt_new;
              seq_o.last_command_ms = now;
              res_o.send_position   = 1'b1;
              res_o.position_value  = pt_new;
            end else if (elapsed > FillTimeoutMs) begin
              // Timeout keeps the fill phase; later ticks still evaluate it.
              seq_o.error     = 1'b1;
              seq_o.complete  = 1'b1;
              res_o.send_stop = 1'b1;
              res_o.finished  = 1'b1;
            end
          end

          StPack: begin
            if (resend) begin
              res_o.send_position   = 1'b1;
              res_o.position_value  = seq_i.pack_target;
              seq_o.last_command_ms = now;
            end
            if (elapsed >= {8'd0, cfg_i.pack_time_ms}) begin
              seq_o.st        = StDone;
              seq_o.complete  = 1'b1;
              res_o.send_stop = 1'b1;
              res_o.finished  = 1'b1;
            end
          end

          default: begin
            res_o.finished = seq_i.complete;
          end
        endcase

        res_o.phase_now   = phase_code(seq_o.st);
        res_o.complete_ok = seq_o.complete && !seq_o.error;
        res_o.error_flag  = seq_o.error;
      end

      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* dv/injection_fill_pack_sequencer_unit_tb.sv */
// ----------------------------------------------------------------------------
// injection_fill_pack_sequencer_unit_tb
// Self-checking testbench for the fill/pack plunger sequencer. Requests go in
// through a bursty valid/ready driver, and results are taken by a receiver
// that stalls on changing patterns. A behavioral model of the sequencer
// predicts every tick result, and each result is compared field by field.
// Directed shots cover fill, pack, timeout, reset re-entry and clamping.
// Randomized shots then run under a range of register settings.
// ----------------------------------------------------------------------------

module injection_fill_pack_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ifps_pkg::*;

  // Sequencer thresholds: 0.1 turn/s and one turn in Q16.16, times in ms.
  localparam longint      VelLowLimit   = 6553;
  localparam longint      CloseLimit    = 65536;
  localparam logic [31:0] SettleTimeMs  = 32'd500;
  localparam logic [31:0] FillTimeLimit = 32'd30000;

  localparam int RandomRounds   = 12;
  localparam int ItemsPerRound  = 170;
  localparam int IdleCycleLimit = 5000;
  localparam int MaxReported    = 10;

  typedef enum int {
    StallNone,
    StallCoin,
    StallPeriodic,
    StallHeavy
  } stall_mode_e;

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [AddrW-1:0]      paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  ifps_in_if  req_if ();
  ifps_out_if res_if ();

  injection_fill_pack_sequencer_unit i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (req_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copy kept by the model.
  logic [23:0]        fill_vol_q;
  logic [23:0]        pack_vol_q;
  logic [23:0]        pack_time_q;
  logic [23:0]        turns_per_vol_q;
  logic signed [31:0] pos_limit_q;
  logic [15:0]        cmd_gap_q;

  // Sequencer state kept by the model.
  logic [1:0]         phase_q;
  logic               entry_q;
  logic [31:0]        phase_start_q;
  logic [31:0]        last_cmd_q;
  logic signed [31:0] fill_tgt_q;
  logic signed [31:0] pack_tgt_q;
  logic               complete_q;
  logic               error_q;

  result_t pending_results[$];

  int burst_left;
  int errors;
  int n_ticks, n_starts, n_resets, n_ignored, n_results;
  int n_pack_entries, n_shots_done, n_timeouts, n_reg_writes;
  logic [31:0] shot_clock_ms;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Target position: position plus scaled volume, clamped from above.
  function automatic logic signed [31:0] shot_target(input logic signed [31:0] pos,
                                                     input logic [23:0] vol);
    logic [47:0] prod;
    longint      sum;
    prod = vol * turns_per_vol_q;
    sum  = longint'(pos) + longint'({32'd0, prod[47:16]});
    if (sum > longint'(pos_limit_q)) begin
      return pos_limit_q;
    end
    return sum[31:0];
  endfunction

  // Advance the model by one request; returns 1 when a result is due.
  function automatic logic sequencer_step(input item_t req, output result_t res);
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic [31:0]        elapsed;
    logic [31:0]        gap2;
    longint             vel_abs;
    longint             pos_err;
    res = '0;
    pos = req.motor_position;
    vel = req.motor_velocity;
    case (req.action)
      ActStart: begin
        phase_q       = PhaseFill;
        entry_q       = 1'b1;
        phase_start_q = req.now_ms;
        last_cmd_q    = req.now_ms;
        complete_q    = 1'b0;
        error_q       = 1'b0;
        return 1'b0;
      end
      ActReset: begin
        phase_q    = PhaseDone;
        entry_q    = 1'b1;
        complete_q = 1'b0;
        error_q    = 1'b0;
        return 1'b0;
      end
      ActTick: begin
      end
      default: begin
        return 1'b0;
      end
    endcase

    elapsed = req.now_ms - phase_start_q;
    gap2    = {15'd0, cmd_gap_q, 1'b0};

    // First tick after a start or reset captures the fill target.
    if (entry_q) begin
      fill_tgt_q            = shot_target(pos, fill_vol_q);
      res.set_position_mode = 1'b1;
      res.send_position     = 1'b1;
      res.position_value    = fill_tgt_q;
      last_cmd_q            = req.now_ms;
      entry_q               = 1'b0;
    end

    vel_abs = longint'(vel);
    if (vel_abs < 0) begin
      vel_abs = -vel_abs;
    end
    pos_err = longint'(pos) - longint'(fill_tgt_q);
    if (pos_err < 0) begin
      pos_err = -pos_err;
    end

    if (phase_q == PhaseFill) begin
      if ((req.now_ms - last_cmd_q) >= gap2) begin
        res.send_position  = 1'b1;
        res.position_value = fill_tgt_q;
        last_cmd_q         = req.now_ms;
      end
      if (vel_abs <= VelLowLimit && elapsed > SettleTimeMs && pos_err < CloseLimit) begin
        phase_q            = PhasePack;
        phase_start_q      = req.now_ms;
        pack_tgt_q         = shot_target(pos, pack_vol_q);
        res.send_position  = 1'b1;
        res.position_value = pack_tgt_q;
        last_cmd_q         = req.now_ms;
        n_pack_entries++;
      end else if (elapsed > FillTimeLimit) begin
        error_q       = 1'b1;
        complete_q    = 1'b1;
        res.send_stop = 1'b1;
        res.finished  = 1'b1;
      end
    end else if (phase_q == PhasePack) begin
      if ((req.now_ms - last_cmd_q) >= gap2) begin
        res.send_position  = 1'b1;
        res.position_value = pack_tgt_q;
        last_cmd_q         = req.now_ms;
      end
      if (elapsed >= {8'd0, pack_time_q}) begin
        phase_q       = PhaseDone;
        complete_q    = 1'b1;
        res.send_stop = 1'b1;
        res.finished  = 1'b1;
      end
    end else begin
      res.finished = complete_q;
    end

    res.phase_now   = phase_q;
    res.complete_ok = complete_q && !error_q;
    res.error_flag  = error_q;
    return 1'b1;
  endfunction

  // Send one request; the sender may idle between bursts of random length.
  task automatic send_request(input logic [1:0] act, input logic [31:0] now,
                              input logic [31:0] pos, input logic [31:0] vel);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 24);
    end
    req_if.valid          <= 1'b1;
    req_if.action         <= act;
    req_if.now_ms         <= now;
    req_if.motor_position <= pos;
    req_if.motor_velocity <= vel;
    do @(posedge clk); while (!req_if.ready);
    burst_left--;
  endtask

  // Stop sending and let every outstanding request drain.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      RegFillVolume:     fill_vol_q      = value[23:0];
      RegPackVolume:     pack_vol_q      = value[23:0];
      RegPackTimeMs:     pack_time_q     = value[23:0];
      RegTurnsPerVolume: turns_per_vol_q = value[23:0];
      RegPositionLimit:  pos_limit_q     = value;
      RegCommandGapMs:   cmd_gap_q       = value[15:0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // Ticks in the done phase right after reset, and an unused action code.
  task automatic test_idle_ticks();
    send_request(ActTick, 32'd100, 32'd0, 32'd0);
    send_request(2'd3, 32'd110, 32'hffff_ffff, 32'hffff_ffff);
    send_request(ActTick, 32'd120, 32'h8000_0000, 32'h7fff_ffff);
    wait_idle();
  endtask

  // A full shot: entry, resend, settle into pack, pack timeout, done.
  task automatic test_fill_then_pack();
    write_reg(RegFillVolume, 32'h0001_0000);
    write_reg(RegPackVolume, 32'h0000_8000);
    write_reg(RegPackTimeMs, 32'd200);
    write_reg(RegTurnsPerVolume, 32'h0001_0000);
    write_reg(RegPositionLimit, 32'h7fff_ffff);
    write_reg(RegCommandGapMs, 32'd10);
    send_request(ActStart, 32'd1000, 32'd0, 32'd0);
    send_request(ActTick, 32'd1005, 32'h0001_0000, 32'h0010_0000);
    send_request(ActTick, 32'd1030, 32'h0001_8000, 32'd6553);
    // One turn away from the target is not yet close.
    send_request(ActTick, 32'd1490, 32'h0001_0000, 32'd0);
    send_request(ActTick, 32'd1501, 32'h0001_0001, -32'sd6553);
    send_request(ActTick, 32'd1510, 32'h0001_0001, 32'd0);
    send_request(ActTick, 32'd1701, 32'h0001_0001, 32'd0);
    send_request(ActTick, 32'd1800, 32'h0001_0001, 32'd0);
    wait_idle();
  endtask

  // Entry and the move to pack on one tick, across a timestamp wrap.
  task automatic test_pack_on_entry();
    write_reg(RegFillVolume, 32'h0000_0000);
    write_reg(RegPackVolume, 32'h00ff_ffff);
    write_reg(RegPackTimeMs, 32'd0);
    send_request(ActStart, 32'hffff_ff00, 32'd0, 32'd0);
    send_request(ActTick, 32'h0000_0100, -32'sd5, 32'd0);
    send_request(ActTick, 32'h0000_0100, -32'sd5, 32'd0);
    send_request(ActTick, 32'h0000_0180, -32'sd5, 32'd0);
    wait_idle();
  endtask

  // Fill timeout with a resend on every tick, then a reset and re-entry.
  task automatic test_fill_timeout();
    write_reg(RegCommandGapMs, 32'd0);
    write_reg(RegFillVolume, 32'h00ff_ffff);
    write_reg(RegTurnsPerVolume, 32'h00ff_ffff);
    write_reg(RegPositionLimit, 32'hffff_0000);
    send_request(ActStart, 32'd50, 32'd0, 32'd0);
    send_request(ActTick, 32'd60, 32'h7fff_ffff, 32'h8000_0000);
    send_request(ActTick, 32'd30050, 32'd0, 32'h7fff_ffff);
    send_request(ActTick, 32'd30051, 32'h8000_0000, 32'd0);
    send_request(ActTick, 32'd30052, 32'h8000_0000, 32'd0);
    send_request(ActReset, 32'd30060, 32'd0, 32'd0);
    send_request(ActTick, 32'd30070, 32'd0, 32'd0);
    send_request(ActTick, 32'd30080, 32'd0, 32'd0);
    wait_idle();
  endtask

  // Random shots under changing settings, mixed with noise requests.
  task automatic test_random_shots();
    logic [23:0]        fv, pv, pt, tpv;
    logic [31:0]        lim;
    logic [15:0]        gap;
    logic [31:0]        pos0;
    logic signed [31:0] tgt;
    logic [1:0]         act;
    int                 sent;
    int                 ticks;
    shot_clock_ms = $urandom;
    for (int r = 0; r < RandomRounds; r++) begin
      if (r == 0) begin
        fv = '0; pv = '0; pt = '0; tpv = '0; lim = 32'h8000_0000; gap = '0;
      end else if (r == 1) begin
        fv = '1; pv = '1; pt = '1; tpv = '1; lim = 32'h7fff_ffff; gap = '1;
      end else begin
        fv  = $urandom_range(0, 24'h04_0000);
        pv  = $urandom_range(0, 24'h04_0000);
        pt  = $urandom_range(0, 1500);
        tpv = $urandom_range(0, 24'h03_0000);
        lim = ($urandom_range(0, 1) == 0) ? 32'h7fff_ffff : $urandom;
        gap = $urandom_range(0, 60);
      end
      // Upper bits beyond each register's width carry garbage.
      write_reg(RegTurnsPerVolume, {8'($urandom), tpv});
      write_reg(RegFillVolume, {8'($urandom), fv});
      write_reg(RegPackVolume, {8'($urandom), pv});
      write_reg(RegPackTimeMs, {8'($urandom), pt});
      write_reg(RegPositionLimit, lim);
      write_reg(RegCommandGapMs, {16'($urandom), gap});

      sent = 0;
      while (sent < ItemsPerRound) begin
        if ($urandom_range(0, 6) == 0) begin
          send_request(2'($urandom), $urandom, $urandom, $urandom);
          sent++;
        end else begin
          shot_clock_ms += $urandom_range(0, 3000);
          act = ($urandom_range(0, 7) == 0) ? ActReset : ActStart;
          send_request(act, shot_clock_ms, $urandom, $urandom);
          pos0 = ($urandom_range(0, 3) == 0) ? $urandom
                 : $urandom_range(0, 32'h20_0000) - 32'h10_0000;
          tgt   = shot_target(pos0, fill_vol_q);
          ticks = $urandom_range(15, 60);
          sent += ticks + 1;
          shot_clock_ms += $urandom_range(0, 50);
          send_request(ActTick, shot_clock_ms, pos0, $urandom);
          // Mostly settle near the target; now and then jump far ahead.
          repeat (ticks - 1) begin
            shot_clock_ms += ($urandom_range(0, 24) == 0) ? $urandom_range(0, 40000)
                                                          : $urandom_range(0, 80);
            act = ($urandom_range(0, 39) == 0) ? 2'($urandom_range(1, 3)) : ActTick;
            send_request(act, shot_clock_ms,
                         ($urandom_range(0, 3) == 0) ? $urandom
                         : tgt + ($urandom_range(0, 140000) - 70000),
                         ($urandom_range(0, 3) == 0) ? $urandom
                         : $urandom_range(0, 14000) - 7000);
          end
        end
      end
      wait_idle();
    end
  endtask

  // Predict on each accepted request, check each accepted result.
  always @(posedge clk) begin : result_check
    result_t exp_res;
    result_t got;
    item_t   req;
    string   bad;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        got.set_position_mode = res_if.set_position_mode;
        got.send_position     = res_if.send_position;
        got.position_value    = res_if.position_value;
        got.send_stop         = res_if.send_stop;
        got.finished          = res_if.finished;
        got.phase_now         = res_if.phase_now;
        got.complete_ok       = res_if.complete_ok;
        got.error_flag        = res_if.error_flag;
        n_results++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MaxReported) begin
            $display("ERROR: result with no request waiting: %p", got);
          end
        end else begin
          exp_res = pending_results.pop_front();
          bad = "";
          if (got.set_position_mode !== exp_res.set_position_mode) bad = {bad, " mode"};
          if (got.send_position !== exp_res.send_position) bad = {bad, " send_position"};
          if (got.position_value !== exp_res.position_value) bad = {bad, " position_value"};
          if (got.send_stop !== exp_res.send_stop) bad = {bad, " send_stop"};
          if (got.finished !== exp_res.finished) bad = {bad, " finished"};
          if (got.phase_now !== exp_res.phase_now) bad = {bad, " phase_now"};
          if (got.complete_ok !== exp_res.complete_ok) bad = {bad, " complete_ok"};
          if (got.error_flag !== exp_res.error_flag) bad = {bad, " error_flag"};
          if (bad != "") begin
            errors++;
            if (errors <= MaxReported) begin
              $display("ERROR: result %0d differs in%s", n_results, bad);
              $display("  expected %p", exp_res);
              $display("  actual   %p", got);
            end
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        req.action         = req_if.action;
        req.now_ms         = req_if.now_ms;
        req.motor_position = req_if.motor_position;
        req.motor_velocity = req_if.motor_velocity;
        case (req.action)
          ActTick:  n_ticks++;
          ActStart: n_starts++;
          ActReset: n_resets++;
          default:  n_ignored++;
        endcase
        if (sequencer_step(req, exp_res)) begin
          if (exp_res.send_stop && exp_res.error_flag) n_timeouts++;
          if (exp_res.send_stop && !exp_res.error_flag) n_shots_done++;
          pending_results.push_back(exp_res);
        end
      end
    end
  end

  // Receiver backpressure, switching between stall patterns.
  initial begin : result_stall
    stall_mode_e mode;
    int          run;
    res_if.ready <= 1'b0;
    mode = StallNone;
    run  = 0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        run  = $urandom_range(20, 120);
      end
      run--;
      case (mode)
        StallNone:     res_if.ready <= 1'b1;
        StallCoin:     res_if.ready <= ($urandom_range(0, 1) == 1);
        StallPeriodic: res_if.ready <= ((run % 4) != 0);
        default:       res_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog: end the run when no handshake completes for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleCycleLimit) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
             IdleCycleLimit, pending_results.size());
    $display("FAIL injection_fill_pack_sequencer_unit");
    $finish;
  end

  // Main sequence.
  initial begin : main_seq
    fill_vol_q      = '0;
    pack_vol_q      = '0;
    pack_time_q     = '0;
    turns_per_vol_q = 24'd65536;
    pos_limit_q     = 32'sh7fff_ffff;
    cmd_gap_q       = 16'd10;
    phase_q         = PhaseDone;
    entry_q         = 1'b0;
    phase_start_q   = '0;
    last_cmd_q      = '0;
    fill_tgt_q      = '0;
    pack_tgt_q      = '0;
    complete_q      = 1'b0;
    error_q         = 1'b0;
    burst_left      = 0;
    errors          = 0;

    rst_n                 <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.action         <= ActTick;
    req_if.now_ms         <= '0;
    req_if.motor_position <= '0;
    req_if.motor_velocity <= '0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_fill_then_pack();
    test_pack_on_entry();
    test_fill_timeout();
    test_random_shots();

    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("ERROR: %0d expected results never arrived", pending_results.size());
    end

    $display("Covered %0d requests: %0d ticks, %0d starts, %0d resets, %0d ignored.",
             n_ticks + n_starts + n_resets + n_ignored, n_ticks, n_starts, n_resets,
             n_ignored);
    $display("Saw %0d pack entries, %0d completed shots, %0d fill timeouts, %0d writes.",
             n_pack_entries, n_shots_done, n_timeouts, n_reg_writes);
    if (errors == 0) begin
      $display("PASS injection_fill_pack_sequencer_unit");
    end else begin
      $display("FAIL injection_fill_pack_sequencer_unit");
    end
    $finish;
  end

endmodule
